/* rtl/att_pkg.sv */
// Shared types and constants for the allocation tracking table.
// Used by the controller, the datapath and the top level; no dependencies.
package att_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned FILE_W = 32;
  localparam int unsigned LINE_W = 24;
  localparam int unsigned HW_W   = 7;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NULL_KEY = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISSING  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_REM_SCAN,
    S_REM_AFTER,
    S_DRN_FIND,
    S_DRN_LOAD,
    S_DRN_END,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [FILE_W-1:0] file;
    logic [LINE_W-1:0] line;
  } ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    cap_en;
    logic    clr_all;
    logic    arm_strict;
    logic    disarm_strict;
    logic    clr_idx;
    logic    inc_idx;
    logic    rd_en;
    logic    wr_en;
    logic    lim_add;
    logic    hit_take;
    logic    lim_set_hit;
    logic    clr_valid_idx;
    logic    ent_load;
    logic    ent_clr;
    logic    out_load;
    logic    out_entry;
    logic    out_last;
    status_e out_status;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_zero;
    logic idx_valid;
    logic idx_end;
    logic idx_full;
    logic hit;
    logic cmp_vld;
    logic ent_full;
    logic out_free;
    logic strict;
  } sts_t;

endpackage

/* rtl/att_ctrl.sv */
// Controller state machine of the allocation tracking table.
// Depends on att_pkg; drives commands to att_dpath and reads its status.
module att_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  att_pkg::cmd_e cmd_i,
  input  att_pkg::sts_t sts_i,
  output att_pkg::ctl_t ctl_o,
  output logic          in_stall_o
);
  import att_pkg::*;

  state_e  state_q, state_d;
  status_e fin_q, fin_d;
  logic    accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_START:  state_d = S_FIN;
            CMD_ADD:    state_d = sts_i.key_zero ? S_FIN : S_ADD_SCAN;
            CMD_REMOVE: state_d = sts_i.key_zero ? S_FIN : S_REM_SCAN;
            CMD_STOP:   state_d = S_DRN_FIND;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (sts_i.idx_full || !sts_i.idx_valid) state_d = S_FIN;
      end
      S_REM_SCAN: begin
        if (sts_i.hit) state_d = S_REM_AFTER;
        else if (sts_i.idx_end && !sts_i.cmp_vld) state_d = S_FIN;
      end
      S_REM_AFTER: begin
        if (sts_i.idx_end || sts_i.idx_valid) state_d = S_FIN;
      end
      S_DRN_FIND: begin
        if (sts_i.idx_end) state_d = S_DRN_END;
        else if (sts_i.idx_valid) state_d = S_DRN_LOAD;
      end
      S_DRN_LOAD: begin
        if (!sts_i.ent_full || sts_i.out_free) state_d = S_DRN_FIND;
      end
      S_DRN_END: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_FIN: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    ctl_o = '0;
    ctl_o.out_status = ST_OK;
    fin_d = fin_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.cap_en = 1'b1;
          ctl_o.clr_idx = 1'b1;
          fin_d = ST_OK;
          unique case (cmd_i) inside
            CMD_START: begin
              ctl_o.clr_all = 1'b1;
              ctl_o.arm_strict = 1'b1;
            end
            CMD_ADD, CMD_REMOVE: begin
              if (sts_i.key_zero) fin_d = ST_NULL_KEY;
            end
            CMD_STOP: begin
              ctl_o.disarm_strict = 1'b1;
              ctl_o.ent_clr = 1'b1;
            end
            default: fin_d = ST_OK;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (sts_i.idx_full) begin
          fin_d = ST_FULL;
        end else if (!sts_i.idx_valid) begin
          ctl_o.wr_en = 1'b1;
          ctl_o.lim_add = 1'b1;
        end else begin
          ctl_o.inc_idx = 1'b1;
        end
      end
      S_REM_SCAN: begin
        // Reads run one slot ahead of the key compare.
        if (sts_i.hit) begin
          ctl_o.hit_take = 1'b1;
        end else if (!sts_i.idx_end) begin
          ctl_o.rd_en = 1'b1;
          ctl_o.inc_idx = 1'b1;
        end else if (!sts_i.cmp_vld) begin
          fin_d = sts_i.strict ? ST_MISSING : ST_OK;
        end
      end
      S_REM_AFTER: begin
        if (sts_i.idx_end) ctl_o.lim_set_hit = 1'b1;
        else if (!sts_i.idx_valid) ctl_o.inc_idx = 1'b1;
      end
      S_DRN_FIND: begin
        if (!sts_i.idx_end) begin
          if (sts_i.idx_valid) begin
            ctl_o.rd_en = 1'b1;
            ctl_o.clr_valid_idx = 1'b1;
          end else begin
            ctl_o.inc_idx = 1'b1;
          end
        end
      end
      S_DRN_LOAD: begin
        // The held entry goes out once the next live one is known.
        if (!sts_i.ent_full || sts_i.out_free) begin
          ctl_o.out_load = sts_i.ent_full;
          ctl_o.out_entry = 1'b1;
          ctl_o.ent_load = 1'b1;
          ctl_o.inc_idx = 1'b1;
        end
      end
      S_DRN_END: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_entry = sts_i.ent_full;
          ctl_o.out_last = 1'b1;
          ctl_o.ent_clr = 1'b1;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_last = 1'b1;
          ctl_o.out_status = fin_q;
        end
      end
      default: fin_d = fin_q;
    endcase
  end

endmodule

/* rtl/att_dpath.sv */
// Datapath of the allocation tracking table: slot memory, valid bits,
// scan counter, scan limit, strict mode and the result register. Uses att_pkg.
module att_dpath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  att_pkg::ctl_t                ctl_i,
  output att_pkg::sts_t                sts_o,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_data_i,
  input  logic [att_pkg::KEY_W-1:0]    key_i,
  input  logic [att_pkg::SIZE_W-1:0]   alloc_size_i,
  input  logic [att_pkg::FILE_W-1:0]   file_tag_i,
  input  logic [att_pkg::LINE_W-1:0]   line_no_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output att_pkg::status_e             status_o,
  output logic                         entry_valid_o,
  output att_pkg::ent_t                entry_o,
  output logic [att_pkg::HW_W-1:0]     high_water_o,
  output logic                         last_o
);
  import att_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ent_t             mem [DEPTH];
  ent_t             rd_q;
  ent_t             req_q;
  ent_t             ent_q;
  logic             ent_full_q;
  logic [DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    cmp_idx_q;
  logic             cmp_vld_q;
  logic [CW-1:0]    hit_idx_q;
  logic [CW-1:0]    limit_q, limit_d;
  logic             cfg_q;
  logic             strict_q;
  logic [AW-1:0]    idx_a, cmp_a;
  logic             out_valid_q;
  logic             out_free;

  assign idx_a    = idx_q[AW-1:0];
  assign cmp_a    = cmp_idx_q[AW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.key_zero  = (key_i == '0);
  assign sts_o.idx_valid = (idx_q < CW'(DEPTH)) && valid_q[idx_a];
  assign sts_o.idx_end   = (idx_q >= limit_q);
  assign sts_o.idx_full  = (idx_q == CW'(DEPTH));
  assign sts_o.hit       = cmp_vld_q && valid_q[cmp_a] && (rd_q.key == req_q.key);
  assign sts_o.cmp_vld   = cmp_vld_q;
  assign sts_o.ent_full  = ent_full_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.strict    = strict_q;

  // Slot memory: one write and one registered read per cycle, both at idx.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) mem[idx_a] <= req_q;
    if (ctl_i.rd_en) rd_q <= mem[idx_a];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_en) begin
      req_q.key  <= key_i;
      req_q.size <= alloc_size_i;
      req_q.file <= file_tag_i;
      req_q.line <= line_no_i;
    end
    if (ctl_i.ent_load) ent_q <= rd_q;
    if (ctl_i.rd_en) cmp_idx_q <= idx_q;
    if (ctl_i.hit_take) hit_idx_q <= cmp_idx_q;
  end

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.clr_all) valid_d = '0;
    if (ctl_i.wr_en) valid_d[idx_a] = 1'b1;
    if (ctl_i.hit_take) valid_d[cmp_a] = 1'b0;
    if (ctl_i.clr_valid_idx) valid_d[idx_a] = 1'b0;
  end

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.clr_idx) idx_d = '0;
    else if (ctl_i.hit_take) idx_d = cmp_idx_q + CW'(1);
    else if (ctl_i.inc_idx) idx_d = idx_q + CW'(1);
  end

  always_comb begin
    limit_d = limit_q;
    if (ctl_i.clr_all) limit_d = '0;
    else if (ctl_i.lim_add && (idx_q + CW'(1) > limit_q)) limit_d = idx_q + CW'(1);
    else if (ctl_i.lim_set_hit) limit_d = hit_idx_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      idx_q      <= '0;
      limit_q    <= '0;
      cmp_vld_q  <= 1'b0;
      ent_full_q <= 1'b0;
      cfg_q      <= 1'b0;
      strict_q   <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      limit_q   <= limit_d;
      cmp_vld_q <= ctl_i.rd_en;
      if (ctl_i.ent_clr) ent_full_q <= 1'b0;
      else if (ctl_i.ent_load) ent_full_q <= 1'b1;
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      if (ctl_i.arm_strict) strict_q <= cfg_q;
      else if (ctl_i.disarm_strict) strict_q <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      status_o      <= ctl_i.out_entry ? ST_OK : ctl_i.out_status;
      entry_valid_o <= ctl_i.out_entry;
      entry_o       <= ctl_i.out_entry ? ent_q : '0;
      high_water_o  <= HW_W'(limit_q);
      last_o        <= ctl_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/allocation_tracking_table_core.sv */
// Allocation tracking table: DEPTH slots scanned in order through a
// single-port memory. An add scans to the first free slot, a remove scans up
// to the scan limit and a drain reports the live slots up to the scan limit.
// The next request is taken in the cycle after the final result is loaded.
// Reset clears the valid flags, scan limit and strict mode at once; slot data
// is not cleared.
module allocation_tracking_table_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [att_pkg::KEY_W-1:0]   key_i,
  input  logic [att_pkg::SIZE_W-1:0]  alloc_size_i,
  input  logic [att_pkg::FILE_W-1:0]  file_tag_i,
  input  logic [att_pkg::LINE_W-1:0]  line_no_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        entry_valid_o,
  output logic [att_pkg::KEY_W-1:0]   entry_key_o,
  output logic [att_pkg::SIZE_W-1:0]  entry_size_o,
  output logic [att_pkg::FILE_W-1:0]  entry_file_o,
  output logic [att_pkg::LINE_W-1:0]  entry_line_o,
  output logic [att_pkg::HW_W-1:0]    high_water_o,
  output logic                        last_o
);
  import att_pkg::*;

  ctl_t    ctl;
  sts_t    sts;
  status_e status;
  ent_t    entry;

  assign cfg_ready_o = 1'b1;

  att_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_e'(cmd_i)),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .in_stall_o (in_stall_o)
  );

  att_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .key_i         (key_i),
    .alloc_size_i  (alloc_size_i),
    .file_tag_i    (file_tag_i),
    .line_no_i     (line_no_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status),
    .entry_valid_o (entry_valid_o),
    .entry_o       (entry),
    .high_water_o  (high_water_o),
    .last_o        (last_o)
  );

  assign status_o     = status;
  assign entry_key_o  = entry.key;
  assign entry_size_o = entry.size;
  assign entry_file_o = entry.file;
  assign entry_line_o = entry.line;

endmodule

/* rtl/att_checker.sv */
// Port-level checks for allocation_tracking_table_core, bound to the top level.
// Depends only on the top level's ports.
module att_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        entry_valid_o,
  input logic [63:0] entry_key_o,
  input logic        last_o
);

  // Only drain reports can be followed by more results of the same request.
  a_nonlast_is_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> entry_valid_o)
    else $error("non-final result without an entry");

  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> status_o == 2'd0)
    else $error("entry result with error status");

  a_entry_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> entry_key_o != 64'd0)
    else $error("reported entry has a null key");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_key_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind allocation_tracking_table_core att_checker u_att_checker (.*);
